// ===== hdl/sha256mh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_pkg
// Shared types, constants and tables of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256mh_pkg;

  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [5:0] ROUND_LAST = 6'd63;

  typedef logic [7:0][31:0] hash_words_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_COMP,
    S_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } core_state_t;

  typedef struct packed {
    logic        push;
    logic [31:0] word;
    logic        start;
    logic        init;
  } core_ctrl_t;

  function automatic logic [31:0] sha_iv(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6A09E667;
      3'd1: v = 32'hBB67AE85;
      3'd2: v = 32'h3C6EF372;
      3'd3: v = 32'hA54FF53A;
      3'd4: v = 32'h510E527F;
      3'd5: v = 32'h9B05688C;
      3'd6: v = 32'h1F83D9AB;
      default: v = 32'h5BE0CD19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h428A2F98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hB5C0FBCF;  6'd3:  v = 32'hE9B5DBA5;
      6'd4:  v = 32'h3956C25B;  6'd5:  v = 32'h59F111F1;
      6'd6:  v = 32'h923F82A4;  6'd7:  v = 32'hAB1C5ED5;
      6'd8:  v = 32'hD807AA98;  6'd9:  v = 32'h12835B01;
      6'd10: v = 32'h243185BE;  6'd11: v = 32'h550C7DC3;
      6'd12: v = 32'h72BE5D74;  6'd13: v = 32'h80DEB1FE;
      6'd14: v = 32'h9BDC06A7;  6'd15: v = 32'hC19BF174;
      6'd16: v = 32'hE49B69C1;  6'd17: v = 32'hEFBE4786;
      6'd18: v = 32'h0FC19DC6;  6'd19: v = 32'h240CA1CC;
      6'd20: v = 32'h2DE92C6F;  6'd21: v = 32'h4A7484AA;
      6'd22: v = 32'h5CB0A9DC;  6'd23: v = 32'h76F988DA;
      6'd24: v = 32'h983E5152;  6'd25: v = 32'hA831C66D;
      6'd26: v = 32'hB00327C8;  6'd27: v = 32'hBF597FC7;
      6'd28: v = 32'hC6E00BF3;  6'd29: v = 32'hD5A79147;
      6'd30: v = 32'h06CA6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27B70A85;  6'd33: v = 32'h2E1B2138;
      6'd34: v = 32'h4D2C6DFC;  6'd35: v = 32'h53380D13;
      6'd36: v = 32'h650A7354;  6'd37: v = 32'h766A0ABB;
      6'd38: v = 32'h81C2C92E;  6'd39: v = 32'h92722C85;
      6'd40: v = 32'hA2BFE8A1;  6'd41: v = 32'hA81A664B;
      6'd42: v = 32'hC24B8B70;  6'd43: v = 32'hC76C51A3;
      6'd44: v = 32'hD192E819;  6'd45: v = 32'hD6990624;
      6'd46: v = 32'hF40E3585;  6'd47: v = 32'h106AA070;
      6'd48: v = 32'h19A4C116;  6'd49: v = 32'h1E376C08;
      6'd50: v = 32'h2748774C;  6'd51: v = 32'h34B0BCB5;
      6'd52: v = 32'h391C0CB3;  6'd53: v = 32'h4ED8AA4A;
      6'd54: v = 32'h5B9CCA4F;  6'd55: v = 32'h682E6FF3;
      6'd56: v = 32'h748F82EE;  6'd57: v = 32'h78A5636F;
      6'd58: v = 32'h84C87814;  6'd59: v = 32'h8CC70208;
      6'd60: v = 32'h90BEFFFA;  6'd61: v = 32'hA4506CEB;
      6'd62: v = 32'hBEF9A3F7;
      default: v = 32'hC67178F2;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/sha256mh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_core
// Iterative SHA-256 compression: 16-word schedule window, one round per
// cycle, feed-forward into the chaining value.
// ----------------------------------------------------------------------------
module sha256mh_core
  import sha256mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  core_ctrl_t  ctrl_i,
  output logic        busy_o,
  output hash_words_t chain_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  core_state_t state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] w_r [16];
  hash_words_t v_r;
  hash_words_t chain_r;

  logic [31:0] w_new, big0, big1, chs, maj, t1, t2, s0, s1;

  always_comb begin
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    big1  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    chs   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + chs + sha_k(rnd_r) + w_r[0];
    big0  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = big0 + maj;
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    unique case (state_r)
      C_IDLE: begin
        if (ctrl_i.start) begin
          state_nxt = C_ROUND;
          rnd_nxt   = '0;
        end
      end
      C_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = C_ADD;
        end
      end
      C_ADD:   state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  // schedule window: load words from the byte path, then expand in place
  always_ff @(posedge clk) begin
    if (ctrl_i.push || state_r == C_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= ctrl_i.push ? ctrl_i.word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.start) begin
      v_r <= chain_r;
    end else if (state_r == C_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl_i.init) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha_iv(3'(i));
      end
    end else if (state_r == C_ADD) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + v_r[i];
      end
    end
  end

  assign busy_o  = (state_r != C_IDLE);
  assign chain_o = chain_r;

endmodule

// ===== hdl/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream: byte packing, padding and length sequencer
// around an iterative compression core; emits eight digest words.
// ----------------------------------------------------------------------------
//  channel | tdata                                | tuser      | tlast
//  in_     | [7:0] data_byte                      | byte_valid | end_of_message
//  out_    | [31:0] digest_word, [34:32] word_idx | -          | last_word
//
//  Every 64th byte starts a compression (64 rounds in the shared round unit,
//  then a feed-forward step and a step to hand control back) during which
//  in_tready is low.
//  End of message feeds pad and length bytes at one per cycle through the same
//  path, paused while a compression runs (one or two compressions), then
//  presents eight words, one per accepted output transfer; the input is held
//  off until the last word is taken.
//  Reset (synchronous, rst_n low) restores the initial hash value and clears
//  the counters.
// ----------------------------------------------------------------------------
module sha256_message_hasher
  import sha256mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast
);

  top_state_t  state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        first_r, first_nxt;
  logic        push;
  logic [7:0]  pbyte;
  logic        core_busy;
  logic        core_init;
  core_ctrl_t  core_ctrl;
  hash_words_t chain;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    bits_nxt   = bits_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    push       = 1'b0;
    pbyte      = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    core_init  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          first_nxt = in_tlast;
          if (in_tuser) begin
            push     = 1'b1;
            pbyte    = in_tdata;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_tuser && fill_r == BLOCK_LAST) begin
            state_nxt = S_COMP;
            ret_nxt   = in_tlast ? S_PAD : S_IDLE;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        push      = 1'b1;
        pbyte     = first_r ? PAD_BYTE : 8'h00;
        first_nxt = 1'b0;
        if (fill_r == BLOCK_LAST) begin
          state_nxt = S_COMP;
          ret_nxt   = S_PAD;
        end else if (fill_r + 6'd1 == LEN_POS) begin
          state_nxt = S_LEN;
          idx_nxt   = '0;
        end
      end
      S_LEN: begin
        push    = 1'b1;
        pbyte   = 8'(bits_r >> {~idx_r, 3'b000});
        idx_nxt = idx_r + 3'd1;
        if (idx_r == WORD_LAST) begin
          state_nxt = S_COMP;
          ret_nxt   = S_OUT;
        end
      end
      S_COMP: begin
        if (!core_busy) begin
          state_nxt = ret_r;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            core_init = 1'b1;
            bits_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // byte path: pack big-endian words into the schedule window
  always_comb begin
    fill_nxt        = fill_r;
    acc_nxt         = acc_r;
    core_ctrl.init  = core_init;
    core_ctrl.push  = 1'b0;
    core_ctrl.start = 1'b0;
    core_ctrl.word  = {acc_r, pbyte};
    if (push) begin
      fill_nxt        = fill_r + 6'd1;
      acc_nxt         = {acc_r[15:0], pbyte};
      core_ctrl.push  = (fill_r[1:0] == 2'b11);
      core_ctrl.start = (fill_r == BLOCK_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  sha256mh_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (core_ctrl),
    .busy_o  (core_busy),
    .chain_o (chain)
  );

  assign out_tdata = {5'b00000, idx_r, chain[idx_r]};
  assign out_tlast = (idx_r == WORD_LAST);

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while digest pending");

  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> !in_tready && !out_tvalid)
    else $error("transfer while compression runs");

  a_fill_tracks_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> bits_r[8:3] == fill_r && bits_r[2:0] == 3'b000)
    else $error("fill count out of step with bit length");

  a_chain_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> chain[0] == sha_iv(3'd0) && fill_r == '0)
    else $error("chaining value not restored after digest");

endmodule
